// File: design/saso_pkg.sv
package saso_pkg;

   localparam int SLOT_W    = 12;
   localparam int GRAD_W    = 32;
   localparam int WEIGHT_W  = 48;
   localparam int SCALE_W   = 39;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int MAG_W     = 31;
   localparam int STEP_W    = 41;
   localparam int RAM_W     = 1 + SCALE_W + WEIGHT_W;
   localparam int WSUM_W    = WEIGHT_W + 2;

   localparam int ENTRIES_DEF = 4096;

   // shared multiplier: 21 x 32 partial products into a 72 bit accumulator
   localparam int MUL_A_W  = 21;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 72;
   localparam int SH_W     = 5;
   localparam int SC_SPLIT = 20;
   localparam int ST_SPLIT = 21;

   localparam int FACTOR_SH = 28;
   localparam int RATE_SH   = 30;
   localparam int GRAD_SH   = 24;

   localparam logic [SCALE_W-1:0] ONE_Q832  = 39'd4294967296;
   localparam logic [SCALE_W-1:0] SCALE_MAX = 39'd429496729600;
   localparam logic [SCALE_W-1:0] SCALE_MIN = 39'd43;

   localparam logic signed [GRAD_W-1:0] GRAD_LIM     = 32'sd1677721600;
   localparam logic signed [GRAD_W-1:0] GRAD_NEG_LIM = -32'sd1677721600;

   localparam logic [CFG_W-1:0] RATE_RST   = 32'd1073742;
   localparam logic [CFG_W-1:0] GROW_RST   = 32'd322122547;
   localparam logic [CFG_W-1:0] SHRINK_RST = 32'd134217728;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_RATE   = 2'd0,
      CSR_GROW_FACTOR = 2'd1,
      CSR_SHRINK_FACT = 2'd2
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_SC0,
      ST_SC1,
      ST_SC2,
      ST_SC3,
      ST_ST0,
      ST_ST1,
      ST_ST2,
      ST_ST3,
      ST_DL0,
      ST_DL1,
      ST_DL2,
      ST_DL3,
      ST_WB
   } state_type;

   typedef enum logic [2:0] {
      MS_SCALE_LO,
      MS_SCALE_HI,
      MS_STEP_LO,
      MS_STEP_HI,
      MS_DELTA_LO,
      MS_DELTA_HI
   } mul_sel_type;

   typedef struct packed {
      logic        clr_wr;
      logic        cap_req;
      logic        rd_en;
      logic        cap_entry;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        upd_scale;
      logic        upd_step;
      logic        upd_weight;
      logic        ram_wr;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic load_mode;
      logic grad_zero;
      logic clear_last;
   } dp_status_type;

endpackage

// File: design/saso_ram.sv
module saso_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/saso_ctrl.sv
module saso_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  saso_pkg::dp_status_type status,
   output saso_pkg::ctrl_cmd_type  cmd
);

   saso_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= saso_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         saso_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clear_last) begin
               state_in = saso_pkg::ST_IDLE;
            end
         end
         saso_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               state_in    = saso_pkg::ST_ADDR;
            end
         end
         saso_pkg::ST_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = status.load_mode ? saso_pkg::ST_WB : saso_pkg::ST_READ;
         end
         saso_pkg::ST_READ: begin
            cmd.cap_entry = 1'b1;
            state_in      = status.grad_zero ? saso_pkg::ST_WB : saso_pkg::ST_SC0;
         end
         // scale times factor
         saso_pkg::ST_SC0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = saso_pkg::MS_SCALE_LO;
            state_in    = saso_pkg::ST_SC1;
         end
         saso_pkg::ST_SC1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = saso_pkg::MS_SCALE_HI;
            cmd.acc_load = 1'b1;
            state_in     = saso_pkg::ST_SC2;
         end
         saso_pkg::ST_SC2: begin
            cmd.acc_add = 1'b1;
            state_in    = saso_pkg::ST_SC3;
         end
         saso_pkg::ST_SC3: begin
            cmd.upd_scale = 1'b1;
            state_in      = saso_pkg::ST_ST0;
         end
         // step rate times scale
         saso_pkg::ST_ST0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = saso_pkg::MS_STEP_LO;
            state_in    = saso_pkg::ST_ST1;
         end
         saso_pkg::ST_ST1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = saso_pkg::MS_STEP_HI;
            cmd.acc_load = 1'b1;
            state_in     = saso_pkg::ST_ST2;
         end
         saso_pkg::ST_ST2: begin
            cmd.acc_add = 1'b1;
            state_in    = saso_pkg::ST_ST3;
         end
         saso_pkg::ST_ST3: begin
            cmd.upd_step = 1'b1;
            state_in     = saso_pkg::ST_DL0;
         end
         // step times gradient magnitude
         saso_pkg::ST_DL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = saso_pkg::MS_DELTA_LO;
            state_in    = saso_pkg::ST_DL1;
         end
         saso_pkg::ST_DL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = saso_pkg::MS_DELTA_HI;
            cmd.acc_load = 1'b1;
            state_in     = saso_pkg::ST_DL2;
         end
         saso_pkg::ST_DL2: begin
            cmd.acc_add = 1'b1;
            state_in    = saso_pkg::ST_DL3;
         end
         saso_pkg::ST_DL3: begin
            cmd.upd_weight = 1'b1;
            state_in       = saso_pkg::ST_WB;
         end
         saso_pkg::ST_WB: begin
            cmd.ram_wr = 1'b1;
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = saso_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = saso_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != saso_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/saso_datapath.sv
module saso_datapath #(
   parameter int ENTRIES = saso_pkg::ENTRIES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  saso_pkg::ctrl_cmd_type                 cmd,
   output saso_pkg::dp_status_type                status,
   input  logic                                   csr_wr,
   input  logic [saso_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [saso_pkg::CFG_W-1:0]             csr_data,
   input  logic                                   req_mode,
   input  logic [saso_pkg::SLOT_W-1:0]            req_slot,
   input  logic signed [saso_pkg::GRAD_W-1:0]     req_grad_value,
   input  logic signed [saso_pkg::WEIGHT_W-1:0]   req_load_value,
   output logic [saso_pkg::SLOT_W-1:0]            rsp_slot_out,
   output logic signed [saso_pkg::WEIGHT_W-1:0]   rsp_weight_out,
   output logic [saso_pkg::SCALE_W-1:0]           rsp_scale_out
);

   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int RECIP_SH = 24;
   localparam int RECIP    = ((1 << RECIP_SH) + ENTRIES - 1) / ENTRIES;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int QPROD_W  = saso_pkg::SLOT_W + RECIP_W;
   localparam int MOD_W    = saso_pkg::SLOT_W + $clog2(ENTRIES + 1) + 1;
   localparam int SCL_V_W  = saso_pkg::ACC_W - saso_pkg::FACTOR_SH;
   localparam int W_TOP    = saso_pkg::WSUM_W - saso_pkg::WEIGHT_W + 1;

   localparam logic signed [saso_pkg::WSUM_W-1:0] WSUM_MAX =
      {{W_TOP{1'b0}}, {(saso_pkg::WEIGHT_W-1){1'b1}}};
   localparam logic signed [saso_pkg::WSUM_W-1:0] WSUM_MIN =
      {{W_TOP{1'b1}}, {(saso_pkg::WEIGHT_W-1){1'b0}}};

   logic [saso_pkg::CFG_W-1:0]    rate_ff, grow_ff, shrink_ff;
   logic [IDX_W-1:0]              clr_cnt_ff;
   logic                          mode_ff;
   logic [saso_pkg::SLOT_W-1:0]   slot_ff;
   logic [saso_pkg::SLOT_W-1:0]   quot_ff;
   logic [saso_pkg::GRAD_W-1:0]   grad_ff;
   logic [saso_pkg::GRAD_W-1:0]   grad_in;
   logic [IDX_W-1:0]              entry_ff;
   logic [saso_pkg::WEIGHT_W-1:0] weight_ff;
   logic [saso_pkg::SCALE_W-1:0]  scale_ff;
   logic                          sign_ff;
   logic [saso_pkg::PROD_W-1:0]   prod_ff;
   logic [saso_pkg::SH_W-1:0]     sh_ff, sh_in;
   logic [saso_pkg::ACC_W-1:0]    acc_ff;
   logic [saso_pkg::STEP_W-1:0]   step_ff;
   logic [saso_pkg::SLOT_W-1:0]   out_slot_ff;
   logic [saso_pkg::WEIGHT_W-1:0] out_weight_ff;
   logic [saso_pkg::SCALE_W-1:0]  out_scale_ff;

   logic [QPROD_W-1:0]            quot_prod;
   logic [MOD_W-1:0]              mod_wide;
   logic [IDX_W-1:0]              entry_in;
   logic                          grad_neg;
   logic [saso_pkg::GRAD_W-1:0]   grad_negated;
   logic [saso_pkg::MAG_W-1:0]    mag;
   logic [saso_pkg::CFG_W-1:0]    factor;
   logic [saso_pkg::MUL_A_W-1:0]  mul_a;
   logic [saso_pkg::MUL_B_W-1:0]  mul_b;
   logic [saso_pkg::PROD_W-1:0]   prod_in;
   logic [saso_pkg::ACC_W-1:0]    acc_shifted;
   logic [SCL_V_W-1:0]            scale_raw;
   logic [saso_pkg::SCALE_W-1:0]  scale_clip;
   logic [saso_pkg::WSUM_W-1:0]   delta_ext;
   logic signed [saso_pkg::WSUM_W-1:0] weight_sum;
   logic [saso_pkg::WEIGHT_W-1:0] weight_sat;
   logic [saso_pkg::RAM_W-1:0]    ram_wdata, ram_rdata;
   logic [IDX_W-1:0]              ram_waddr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= saso_pkg::RATE_RST;
         grow_ff   <= saso_pkg::GROW_RST;
         shrink_ff <= saso_pkg::SHRINK_RST;
      end else if (csr_wr) begin
         case (saso_pkg::csr_reg_type'(csr_index))
            saso_pkg::CSR_STEP_RATE:   rate_ff   <= csr_data;
            saso_pkg::CSR_GROW_FACTOR: grow_ff   <= csr_data;
            saso_pkg::CSR_SHRINK_FACT: shrink_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // gradient clip
   always_comb begin
      if (req_grad_value > saso_pkg::GRAD_LIM) begin
         grad_in = saso_pkg::GRAD_LIM;
      end else if (req_grad_value < saso_pkg::GRAD_NEG_LIM) begin
         grad_in = saso_pkg::GRAD_NEG_LIM;
      end else begin
         grad_in = req_grad_value;
      end
   end

   // slot modulo entries by reciprocal
   assign quot_prod = QPROD_W'(req_slot) * QPROD_W'(RECIP);
   assign mod_wide  = MOD_W'(slot_ff) - MOD_W'(quot_ff) * MOD_W'(ENTRIES);
   assign entry_in  = mod_wide[IDX_W-1:0];

   assign grad_neg     = grad_ff[saso_pkg::GRAD_W-1];
   assign grad_negated = -grad_ff;
   assign mag          = grad_neg ? grad_negated[saso_pkg::MAG_W-1:0]
                                  : grad_ff[saso_pkg::MAG_W-1:0];
   assign factor       = (grad_neg ^ sign_ff) ? grow_ff : shrink_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sh_in = '0;
      case (cmd.mul_sel)
         saso_pkg::MS_SCALE_LO: begin
            mul_a = saso_pkg::MUL_A_W'(scale_ff[saso_pkg::SC_SPLIT-1:0]);
            mul_b = factor;
         end
         saso_pkg::MS_SCALE_HI: begin
            mul_a = saso_pkg::MUL_A_W'(scale_ff[saso_pkg::SCALE_W-1:saso_pkg::SC_SPLIT]);
            mul_b = factor;
            sh_in = saso_pkg::SH_W'(saso_pkg::SC_SPLIT);
         end
         saso_pkg::MS_STEP_LO: begin
            mul_a = saso_pkg::MUL_A_W'(scale_ff[saso_pkg::SC_SPLIT-1:0]);
            mul_b = rate_ff;
         end
         saso_pkg::MS_STEP_HI: begin
            mul_a = saso_pkg::MUL_A_W'(scale_ff[saso_pkg::SCALE_W-1:saso_pkg::SC_SPLIT]);
            mul_b = rate_ff;
            sh_in = saso_pkg::SH_W'(saso_pkg::SC_SPLIT);
         end
         saso_pkg::MS_DELTA_LO: begin
            mul_a = step_ff[saso_pkg::ST_SPLIT-1:0];
            mul_b = saso_pkg::MUL_B_W'(mag);
         end
         saso_pkg::MS_DELTA_HI: begin
            mul_a = saso_pkg::MUL_A_W'(step_ff[saso_pkg::STEP_W-1:saso_pkg::ST_SPLIT]);
            mul_b = saso_pkg::MUL_B_W'(mag);
            sh_in = saso_pkg::SH_W'(saso_pkg::ST_SPLIT);
         end
         default: ;
      endcase
   end

   assign prod_in     = saso_pkg::PROD_W'(mul_a) * saso_pkg::PROD_W'(mul_b);
   assign acc_shifted = saso_pkg::ACC_W'(prod_ff) << sh_ff;

   // scale clip
   assign scale_raw = acc_ff[saso_pkg::ACC_W-1:saso_pkg::FACTOR_SH];
   always_comb begin
      if (scale_raw > SCL_V_W'(saso_pkg::SCALE_MAX)) begin
         scale_clip = saso_pkg::SCALE_MAX;
      end else if (scale_raw < SCL_V_W'(saso_pkg::SCALE_MIN)) begin
         scale_clip = saso_pkg::SCALE_MIN;
      end else begin
         scale_clip = scale_raw[saso_pkg::SCALE_W-1:0];
      end
   end

   // weight add with saturation
   assign delta_ext  = saso_pkg::WSUM_W'(acc_ff[saso_pkg::GRAD_SH +: saso_pkg::WEIGHT_W]);
   assign weight_sum = $signed({{(saso_pkg::WSUM_W-saso_pkg::WEIGHT_W)
                                 {weight_ff[saso_pkg::WEIGHT_W-1]}}, weight_ff})
                     + $signed(grad_neg ? -delta_ext : delta_ext);
   always_comb begin
      if (weight_sum > WSUM_MAX) begin
         weight_sat = WSUM_MAX[saso_pkg::WEIGHT_W-1:0];
      end else if (weight_sum < WSUM_MIN) begin
         weight_sat = WSUM_MIN[saso_pkg::WEIGHT_W-1:0];
      end else begin
         weight_sat = weight_sum[saso_pkg::WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         mode_ff   <= req_mode;
         slot_ff   <= req_slot;
         quot_ff   <= quot_prod[RECIP_SH +: saso_pkg::SLOT_W];
         grad_ff   <= grad_in;
         weight_ff <= req_load_value;
         scale_ff  <= saso_pkg::ONE_Q832;
         sign_ff   <= 1'b0;
      end
      if (cmd.rd_en) begin
         entry_ff <= entry_in;
      end
      if (cmd.cap_entry) begin
         weight_ff <= ram_rdata[saso_pkg::WEIGHT_W-1:0];
         scale_ff  <= ram_rdata[saso_pkg::WEIGHT_W +: saso_pkg::SCALE_W];
         sign_ff   <= ram_rdata[saso_pkg::RAM_W-1];
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         sh_ff   <= sh_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= acc_shifted;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + acc_shifted;
      end
      if (cmd.upd_scale) begin
         scale_ff <= scale_clip;
         sign_ff  <= !grad_neg;
      end
      if (cmd.upd_step) begin
         step_ff <= acc_ff[saso_pkg::RATE_SH +: saso_pkg::STEP_W];
      end
      if (cmd.upd_weight) begin
         weight_ff <= weight_sat;
      end
      if (cmd.out_load) begin
         out_slot_ff   <= slot_ff;
         out_weight_ff <= weight_ff;
         out_scale_ff  <= scale_ff;
      end
   end

   // clearing pass writes scale 1.0, sign 0
   assign ram_waddr = cmd.clr_wr ? clr_cnt_ff : entry_ff;
   assign ram_wdata = cmd.clr_wr ? {1'b0, saso_pkg::ONE_Q832, {saso_pkg::WEIGHT_W{1'b0}}}
                                 : {sign_ff, scale_ff, weight_ff};

   saso_ram #(
      .DATA_W (saso_pkg::RAM_W),
      .DEPTH  (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_wr | cmd.ram_wr),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (entry_in),
      .rd_data (ram_rdata)
   );

   assign status.load_mode  = mode_ff;
   assign status.grad_zero  = (grad_ff == '0);
   assign status.clear_last = (clr_cnt_ff == IDX_W'(ENTRIES - 1));

   assign rsp_slot_out   = out_slot_ff;
   assign rsp_weight_out = out_weight_ff;
   assign rsp_scale_out  = out_scale_ff;

endmodule

// File: design/sign_adaptive_step_optimizer.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  mode, slot, grad_value, load_value
// rsp_      out        rsp_valid/rsp_stall  slot_out, weight_out, scale_out
// csr_      in         csr_valid/csr_ready  index, data (always ready)
//
// an update transaction runs from acceptance to the next acceptance through a table
// read, then three products, each two partial products through one 21x32 multiplier
// a load skips the table read and the products, a zero gradient skips the products
// after reset a clearing pass fills every table entry, req_stall stays high
// a stalled result sits in the output register and the next transaction is accepted;
// only its writeback waits for the result register to free up
module sign_adaptive_step_optimizer #(
   parameter int ENTRIES = saso_pkg::ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [saso_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [saso_pkg::GRAD_W-1:0]   req_grad_value,
   input  logic signed [saso_pkg::WEIGHT_W-1:0] req_load_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [saso_pkg::SLOT_W-1:0]          rsp_slot_out,
   output logic signed [saso_pkg::WEIGHT_W-1:0] rsp_weight_out,
   output logic [saso_pkg::SCALE_W-1:0]         rsp_scale_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [saso_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [saso_pkg::CFG_W-1:0]           csr_data
);

   saso_pkg::ctrl_cmd_type  cmd;
   saso_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   saso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   saso_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr         (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .req_grad_value (req_grad_value),
      .req_load_value (req_load_value),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_weight_out (rsp_weight_out),
      .rsp_scale_out  (rsp_scale_out)
   );

endmodule

// File: design/saso_checker.sv
module saso_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [saso_pkg::SLOT_W-1:0]          req_slot,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [saso_pkg::SLOT_W-1:0]          rsp_slot_out,
   input logic signed [saso_pkg::WEIGHT_W-1:0] rsp_weight_out,
   input logic [saso_pkg::SCALE_W-1:0]         rsp_scale_out
);

   logic [saso_pkg::SLOT_W-1:0] last_slot_ff;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         last_slot_ff <= req_slot;
      end
   end

   // reset empties the result register and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_stall))
      else $error("reset did not clear result and stall requests");

   // one transaction in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a transaction is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_slot_out)
         && $stable(rsp_weight_out) && $stable(rsp_scale_out)))
      else $error("stalled result changed");

   // a new result belongs to the last accepted request
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_slot_out == last_slot_ff))
      else $error("result slot does not match accepted request");

endmodule

bind sign_adaptive_step_optimizer saso_checker u_checker (.*);

// File: tb/sign_adaptive_step_optimizer_checker.sv
`timescale 1ns / 100ps
module sign_adaptive_step_optimizer_checker #(
   parameter int ENTRIES = saso_pkg::ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [saso_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [saso_pkg::GRAD_W-1:0]   req_grad_value,
   input  logic signed [saso_pkg::WEIGHT_W-1:0] req_load_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [saso_pkg::SLOT_W-1:0]          rsp_slot_out,
   input  logic signed [saso_pkg::WEIGHT_W-1:0] rsp_weight_out,
   input  logic [saso_pkg::SCALE_W-1:0]         rsp_scale_out,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [saso_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [saso_pkg::CFG_W-1:0]           csr_data,
   output int                                   error_count,
   output int                                   pending_count
);

   typedef struct packed {
      logic [saso_pkg::SLOT_W-1:0]   slot;
      logic [saso_pkg::WEIGHT_W-1:0] weight;
      logic [saso_pkg::SCALE_W-1:0]  scale;
   } optimizer_result_type;

   localparam logic signed [saso_pkg::WSUM_W-1:0] WSUM_MAX = 50'sd140737488355327;
   localparam logic signed [saso_pkg::WSUM_W-1:0] WSUM_MIN = -50'sd140737488355328;

   logic signed [saso_pkg::WEIGHT_W-1:0] weight_mem [ENTRIES];
   logic [saso_pkg::SCALE_W-1:0]         scale_mem [ENTRIES];
   bit                                   sign_mem [ENTRIES];
   logic [saso_pkg::CFG_W-1:0]           step_rate;
   logic [saso_pkg::CFG_W-1:0]           grow_factor;
   logic [saso_pkg::CFG_W-1:0]           shrink_factor;
   optimizer_result_type                 expected_results [$];

   function automatic logic [saso_pkg::SCALE_W-1:0] rescale_step(
      input logic [saso_pkg::SCALE_W-1:0] s,
      input logic [saso_pkg::CFG_W-1:0]   factor);
      logic [70:0] prod;
      logic [70:0] v;
      prod = s * factor;
      v = prod >> saso_pkg::FACTOR_SH;
      if (v > saso_pkg::SCALE_MAX) v = saso_pkg::SCALE_MAX;
      if (v < saso_pkg::SCALE_MIN) v = saso_pkg::SCALE_MIN;
      return v[saso_pkg::SCALE_W-1:0];
   endfunction

   task automatic predict_optimizer_step(input logic mode,
                                         input logic [saso_pkg::SLOT_W-1:0] slot,
                                         input logic signed [saso_pkg::GRAD_W-1:0] grad,
                                         input logic signed [saso_pkg::WEIGHT_W-1:0] load);
      int unsigned                          e;
      logic signed [saso_pkg::GRAD_W-1:0]   g;
      logic [saso_pkg::MAG_W-1:0]           mag;
      logic [saso_pkg::STEP_W-1:0]          st;
      logic [71:0]                          prod;
      logic [saso_pkg::WEIGHT_W-1:0]        dmag;
      logic signed [saso_pkg::WSUM_W-1:0]   wsum;
      optimizer_result_type                 res;
      e = slot % ENTRIES;
      if (mode) begin
         weight_mem[e] = load;
         scale_mem[e] = saso_pkg::ONE_Q832;
         sign_mem[e] = 1'b0;
      end else begin
         g = grad;
         if (g > saso_pkg::GRAD_LIM) g = saso_pkg::GRAD_LIM;
         if (g < saso_pkg::GRAD_NEG_LIM) g = saso_pkg::GRAD_NEG_LIM;
         if ((g < 0 && !sign_mem[e]) || (g > 0 && sign_mem[e])) begin
            scale_mem[e] = rescale_step(scale_mem[e], grow_factor);
         end else if (g != 0) begin
            scale_mem[e] = rescale_step(scale_mem[e], shrink_factor);
            sign_mem[e] = (g > 0);
         end
         if (g != 0) begin
            prod = scale_mem[e] * step_rate;
            st = prod >> saso_pkg::RATE_SH;
            mag = (g < 0) ? -g : g;
            prod = st * mag;
            dmag = prod >> saso_pkg::GRAD_SH;
            wsum = weight_mem[e];
            if (g < 0) wsum = wsum - $signed({2'b00, dmag});
            else wsum = wsum + $signed({2'b00, dmag});
            if (wsum > WSUM_MAX) wsum = WSUM_MAX;
            if (wsum < WSUM_MIN) wsum = WSUM_MIN;
            weight_mem[e] = wsum[saso_pkg::WEIGHT_W-1:0];
         end
      end
      res.slot = slot;
      res.weight = weight_mem[e];
      res.scale = scale_mem[e];
      expected_results.push_back(res);
   endtask

   task automatic note_failure(input bit unexpected, input optimizer_result_type exp_r,
                               input optimizer_result_type got_r);
      error_count++;
      if (error_count <= 10) begin
         if (unexpected)
            $display("unexpected transaction: slot %0d weight %h scale %h",
                     got_r.slot, got_r.weight, got_r.scale);
         else
            $display("mismatch: slot exp %0d got %0d, weight exp %h got %h, scale exp %h got %h",
                     exp_r.slot, got_r.slot, exp_r.weight, got_r.weight,
                     exp_r.scale, got_r.scale);
      end
   endtask

   always @(posedge clock) begin : check_proc
      optimizer_result_type got_r;
      optimizer_result_type exp_r;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            weight_mem[i] = '0;
            scale_mem[i] = saso_pkg::ONE_Q832;
            sign_mem[i] = 1'b0;
         end
         step_rate = saso_pkg::RATE_RST;
         grow_factor = saso_pkg::GROW_RST;
         shrink_factor = saso_pkg::SHRINK_RST;
         expected_results.delete();
         error_count = 0;
         pending_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               saso_pkg::CSR_STEP_RATE:   step_rate = csr_data;
               saso_pkg::CSR_GROW_FACTOR: grow_factor = csr_data;
               saso_pkg::CSR_SHRINK_FACT: shrink_factor = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got_r.slot = rsp_slot_out;
            got_r.weight = rsp_weight_out;
            got_r.scale = rsp_scale_out;
            if (expected_results.size() == 0) begin
               note_failure(1'b1, got_r, got_r);
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== got_r) note_failure(1'b0, exp_r, got_r);
            end
         end
         if (req_valid && !req_stall)
            predict_optimizer_step(req_mode, req_slot, req_grad_value, req_load_value);
         pending_count = expected_results.size();
      end
   end

endmodule

// File: tb/tb_sign_adaptive_step_optimizer.sv
`timescale 1ns / 100ps
module tb_sign_adaptive_step_optimizer;

   localparam int ENTRIES     = saso_pkg::ENTRIES_DEF;
   localparam int NUM_PHASES  = 7;
   localparam int PHASE_ITEMS = 142;
   localparam int POOL        = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 100000;

   localparam logic [saso_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;
   localparam logic [saso_pkg::WEIGHT_W-1:0]  W_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [saso_pkg::WEIGHT_W-1:0]  W_MIN = 48'h8000_0000_0000;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_mode;
   logic [saso_pkg::SLOT_W-1:0]          req_slot;
   logic signed [saso_pkg::GRAD_W-1:0]   req_grad_value;
   logic signed [saso_pkg::WEIGHT_W-1:0] req_load_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [saso_pkg::SLOT_W-1:0]          rsp_slot_out;
   logic signed [saso_pkg::WEIGHT_W-1:0] rsp_weight_out;
   logic [saso_pkg::SCALE_W-1:0]         rsp_scale_out;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [saso_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [saso_pkg::CFG_W-1:0]           csr_data;
   int                                   error_count;
   int                                   pending_count;

   bit no_gaps = 1'b0;
   bit hold_off_req = 1'b0;
   bit slot_loaded [ENTRIES];

   sign_adaptive_step_optimizer #(.ENTRIES(ENTRIES)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .req_grad_value (req_grad_value),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_weight_out (rsp_weight_out),
      .rsp_scale_out  (rsp_scale_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   sign_adaptive_step_optimizer_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .req_grad_value (req_grad_value),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_weight_out (rsp_weight_out),
      .rsp_scale_out  (rsp_scale_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [saso_pkg::GRAD_W-1:0] pick_grad(input bit neg);
      logic [saso_pkg::GRAD_W-1:0] mag;
      case ($urandom_range(0, 9))
         0:          mag = $urandom_range(1, 255);
         1, 2, 3, 4: mag = $urandom_range(1, saso_pkg::GRAD_LIM);
         5, 6:       mag = $urandom_range(saso_pkg::GRAD_LIM, 32'h7FFF_FFFF);
         7:          return $urandom;
         8:          return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default:    mag = $urandom_range(1, 32'h0100_0000);
      endcase
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [saso_pkg::WEIGHT_W-1:0] pick_load_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       return W_MAX - $urandom_range(0, 1000);
         1:       return W_MIN + $urandom_range(0, 1000);
         2:       return {{16{raw[31]}}, raw[31:0]};
         default: return raw[saso_pkg::WEIGHT_W-1:0];
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_txn(input logic mode, input logic [saso_pkg::SLOT_W-1:0] slot,
                           input logic signed [saso_pkg::GRAD_W-1:0] grad,
                           input logic signed [saso_pkg::WEIGHT_W-1:0] load);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_slot = slot;
      req_grad_value = grad;
      req_load_value = load;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_load(input logic [saso_pkg::SLOT_W-1:0] slot,
                            input logic signed [saso_pkg::WEIGHT_W-1:0] value);
      slot_loaded[slot] = 1'b1;
      send_txn(1'b1, slot, $urandom, value);
   endtask

   task automatic send_update(input logic [saso_pkg::SLOT_W-1:0] slot,
                              input logic signed [saso_pkg::GRAD_W-1:0] grad);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      // an entry must hold a written weight before its first update
      if (!slot_loaded[slot]) send_load(slot, pick_load_value());
      else send_txn(1'b0, slot, grad, raw[saso_pkg::WEIGHT_W-1:0]);
   endtask

   task automatic write_csr(input logic [saso_pkg::CSR_IDX_W-1:0] idx,
                            input logic [saso_pkg::CFG_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int stall_len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_stall = 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall = 1'b0;
      end
   end

   initial begin
      int                          r;
      int                          drain;
      bit                          run_neg;
      logic [saso_pkg::SLOT_W-1:0] s;
      logic [saso_pkg::SLOT_W-1:0] pool_slot [POOL];
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_slot = '0;
      req_grad_value = '0;
      req_load_value = '0;
      csr_valid = 1'b0;
      csr_index = saso_pkg::CSR_STEP_RATE;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed, reset configuration
      send_load(12'h000, W_MAX);
      send_load(12'hFFF, W_MIN);
      send_load(12'hAAA, '0);
      send_txn(1'b1, 12'h555, 32'h5555_5555, 48'h5555_5555_5555);
      slot_loaded[12'h555] = 1'b1;
      send_update(12'h000, 32'h7FFF_FFFF);
      send_update(12'h000, 32'sd1);
      send_update(12'hFFF, 32'h8000_0000);
      send_update(12'hAAA, '0);
      send_update(12'hAAA, saso_pkg::GRAD_LIM);
      send_update(12'hAAA, saso_pkg::GRAD_NEG_LIM);
      send_update(12'hAAA, -32'sd1);
      send_update(12'h555, saso_pkg::GRAD_LIM + 32'sd1);
      send_update(12'h555, '0);
      send_txn(1'b1, 12'h555, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);

      // directed, extreme configuration
      wait_idle();
      write_csr(saso_pkg::CSR_STEP_RATE, 32'hFFFF_FFFF);
      write_csr(saso_pkg::CSR_GROW_FACTOR, 32'hFFFF_FFFF);
      write_csr(saso_pkg::CSR_SHRINK_FACT, 32'h0000_0000);
      write_csr(CSR_SPARE_IDX, 32'hFFFF_FFFF);
      send_load(12'h123, '0);
      repeat (4) send_update(12'h123, saso_pkg::GRAD_NEG_LIM);
      send_update(12'h123, 32'sd1);
      send_update(12'h123, 32'sd1);
      send_load(12'hEDC, '0);
      repeat (2) send_update(12'hEDC, 32'h7FFF_FFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_csr(saso_pkg::CSR_STEP_RATE, saso_pkg::RATE_RST);
               write_csr(saso_pkg::CSR_GROW_FACTOR, saso_pkg::GROW_RST);
               write_csr(saso_pkg::CSR_SHRINK_FACT, saso_pkg::SHRINK_RST);
            end
            1: begin
               write_csr(saso_pkg::CSR_STEP_RATE, 32'hFFFF_FFFF);
               write_csr(saso_pkg::CSR_GROW_FACTOR, 32'hFFFF_FFFF);
               write_csr(saso_pkg::CSR_SHRINK_FACT, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(saso_pkg::CSR_STEP_RATE, '0);
               write_csr(saso_pkg::CSR_GROW_FACTOR, '0);
               write_csr(saso_pkg::CSR_SHRINK_FACT, '0);
               write_csr(CSR_SPARE_IDX, $urandom);
            end
            3: begin
               write_csr(saso_pkg::CSR_STEP_RATE,
                         $urandom_range(32'h0010_0000, 32'h4000_0000));
               write_csr(saso_pkg::CSR_GROW_FACTOR,
                         $urandom_range(32'h1000_0000, 32'h2000_0000));
               write_csr(saso_pkg::CSR_SHRINK_FACT,
                         $urandom_range(32'h0400_0000, 32'h1000_0000));
            end
            default: begin
               write_csr(saso_pkg::CSR_STEP_RATE, $urandom);
               write_csr(saso_pkg::CSR_GROW_FACTOR, $urandom);
               write_csr(saso_pkg::CSR_SHRINK_FACT, $urandom);
            end
         endcase
         for (int k = 0; k < POOL; k++) begin
            pool_slot[k] = $urandom_range(0, ENTRIES - 1);
            send_load(pool_slot[k], pick_load_value());
         end
         run_neg = $urandom_range(0, 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 60) begin
               no_gaps = 1'b1;
               hold_off_req = 1'b1;
            end
            if (p == 1 && n == 100) no_gaps = 1'b0;
            if (p == 4 && n == 0) no_gaps = 1'b1;
            if (p == 4 && n == 50) no_gaps = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 70) begin
               s = pool_slot[$urandom_range(0, POOL - 1)];
               if ($urandom_range(0, 4) == 0) run_neg = ~run_neg;
               if ($urandom_range(0, 19) == 0) send_update(s, '0);
               else send_update(s, pick_grad(run_neg));
            end else if (r < 80) begin
               send_load(pool_slot[$urandom_range(0, POOL - 1)], pick_load_value());
            end else if (r < 90) begin
               send_load($urandom_range(0, ENTRIES - 1), pick_load_value());
            end else begin
               if ($urandom_range(0, 1) == 0) s = pool_slot[$urandom_range(0, POOL - 1)];
               else s = $urandom_range(0, ENTRIES - 1);
               send_update(s, $urandom);
            end
         end
      end

      req_valid = 1'b0;
      drain = 0;
      while (pending_count != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (40) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
